FILE: rtl/core/rational_arith_gcd_reduce_macros.svh
// assertion macros for the rational reduce block
`ifndef RATIONAL_ARITH_GCD_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_GCD_REDUCE_MACROS_SVH

// checked only outside reset
`define RAG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// checked at every edge, reset included
`define RAG_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/rag_pkg.sv
// shared types and constants for the rational reduce block
`timescale 1ns / 1ps
package rag_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 33;
  localparam int RAW_MAX_W     = 64;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_N,
    ST_MUL_D,
    ST_MUL_X,
    ST_COMB,
    ST_EUC_GO,
    ST_EUC_WAIT,
    ST_NUM_GO,
    ST_NUM_WAIT,
    ST_DEN_GO,
    ST_DEN_WAIT,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/core/rag_div.sv
// shared restoring divider, one quotient bit per cycle, truncating signed result
`timescale 1ns / 1ps
module rag_div #(
  parameter int W = 33
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  input  logic signed [W-1:0] divisor,
  output logic                done,
  output logic signed [W-1:0] quo,
  output logic signed [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W-1:0]  ua;
  logic [W-1:0]  ub;
  logic [W-1:0]  acc;
  logic [W-1:0]  q;
  logic          neg_q;
  logic          neg_r;
  logic [W:0]    trial;
  logic          fits;

  always_comb begin
    trial = {acc, ua[W-1]};
    fits  = trial >= {1'b0, ub};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua    <= dividend[W-1] ? W'(-dividend) : W'(dividend);
      ub    <= divisor[W-1] ? W'(-divisor) : W'(divisor);
      acc   <= '0;
      q     <= '0;
      neg_q <= dividend[W-1] ^ divisor[W-1];
      neg_r <= dividend[W-1];
    end else if (run) begin
      ua  <= ua << 1;
      acc <= fits ? W'(trial - {1'b0, ub}) : trial[W-1:0];
      q   <= {q[W-2:0], fits};
    end
  end

  assign quo = neg_q ? $signed(-q) : $signed(q);
  assign rem = neg_r ? $signed(-acc) : $signed(acc);

endmodule

FILE: rtl/core/rational_arith_gcd_reduce.sv
// top level: rational add/sub/mul/div with euclid reduction
// steps: three multiplies, a combine, then any euclid divisions and one division each
//   for num and den, all RW wide (RW = min(2*OPERAND_WIDTH + 1, 64), 33 by default)
// throughput: one item at a time, set by the single shared bit-serial divider
// reset (rst, synchronous) returns the sequencer to idle and drops out_valid
`timescale 1ns / 1ps
module rational_arith_gcd_reduce #(
  parameter int OPERAND_WIDTH = rag_pkg::OPERAND_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      kind,
  input  logic signed [rag_pkg::IN_W-1:0] a_num,
  input  logic signed [rag_pkg::IN_W-1:0] a_den,
  input  logic signed [rag_pkg::IN_W-1:0] b_num,
  input  logic signed [rag_pkg::IN_W-1:0] b_den,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [rag_pkg::OUT_W-1:0] res_num,
  output logic signed [rag_pkg::OUT_W-1:0] res_den
);

  localparam int OW = OPERAND_WIDTH;
  localparam int RW = (2 * OW + 1 < rag_pkg::RAW_MAX_W) ? 2 * OW + 1 : rag_pkg::RAW_MAX_W;

  rag_pkg::state_t   state, state_next;
  rag_pkg::kind_t    op;

  logic signed [OW-1:0]   an, ad, bn, bd;
  logic signed [OW-1:0]   an_x, ad_x, bn_x, bd_x;
  logic signed [OW-1:0]   mul_a, mul_b;
  logic signed [2*OW-1:0] prod;
  logic signed [RW-1:0]   pn, pd, px;
  logic signed [RW-1:0]   n_raw;
  logic signed [RW-1:0]   n, d, m, k, g;
  logic signed [RW-1:0]   div_a, div_b, quo, rem;
  logic                   div_start;
  logic                   div_done;
  logic                   accept;

  assign accept = in_valid && !in_stall;

  // operands come from the low OW bits of each field, zero filled above IN_W
  always_comb begin
    for (int i = 0; i < OW; i++) begin
      an_x[i] = (i < rag_pkg::IN_W) ? a_num[i] : 1'b0;
      ad_x[i] = (i < rag_pkg::IN_W) ? a_den[i] : 1'b0;
      bn_x[i] = (i < rag_pkg::IN_W) ? b_num[i] : 1'b0;
      bd_x[i] = (i < rag_pkg::IN_W) ? b_den[i] : 1'b0;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = an;
    mul_b = bd;
    unique case (state)
      rag_pkg::ST_MUL_N: begin
        mul_a = an;
        mul_b = (op == rag_pkg::KIND_MUL) ? bn : bd;
      end
      rag_pkg::ST_MUL_D: begin
        mul_a = ad;
        mul_b = (op == rag_pkg::KIND_DIV) ? bn : bd;
      end
      rag_pkg::ST_MUL_X: begin
        mul_a = ad;
        mul_b = bn;
      end
      default: begin
        mul_a = an;
        mul_b = bd;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    unique case (op)
      rag_pkg::KIND_ADD: n_raw = pn + px;
      rag_pkg::KIND_SUB: n_raw = pn - px;
      default:           n_raw = pn;
    endcase
  end

  // divider operand select
  always_comb begin
    div_a = m;
    div_b = k;
    unique case (state)
      rag_pkg::ST_NUM_GO: begin
        div_a = n;
        div_b = g;
      end
      rag_pkg::ST_DEN_GO: begin
        div_a = d;
        div_b = g;
      end
      default: begin
        div_a = m;
        div_b = k;
      end
    endcase
  end

  assign div_start = state == rag_pkg::ST_EUC_GO || state == rag_pkg::ST_NUM_GO ||
                     state == rag_pkg::ST_DEN_GO;

  rag_div #(.W(RW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rag_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      rag_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = rag_pkg::ST_MUL_N;
      end
      rag_pkg::ST_MUL_N: state_next = rag_pkg::ST_MUL_D;
      rag_pkg::ST_MUL_D: state_next = rag_pkg::ST_MUL_X;
      rag_pkg::ST_MUL_X: state_next = rag_pkg::ST_COMB;
      rag_pkg::ST_COMB: begin
        // a zero raw value skips euclid, divisor is one
        if (n_raw == '0 || pd == '0) state_next = rag_pkg::ST_NUM_GO;
        else                         state_next = rag_pkg::ST_EUC_GO;
      end
      rag_pkg::ST_EUC_GO: state_next = rag_pkg::ST_EUC_WAIT;
      rag_pkg::ST_EUC_WAIT: begin
        if (div_done) begin
          state_next = (rem == '0) ? rag_pkg::ST_NUM_GO : rag_pkg::ST_EUC_GO;
        end
      end
      rag_pkg::ST_NUM_GO: state_next = rag_pkg::ST_NUM_WAIT;
      rag_pkg::ST_NUM_WAIT: begin
        if (div_done) state_next = rag_pkg::ST_DEN_GO;
      end
      rag_pkg::ST_DEN_GO: state_next = rag_pkg::ST_DEN_WAIT;
      rag_pkg::ST_DEN_WAIT: begin
        if (div_done) state_next = rag_pkg::ST_OUT;
      end
      rag_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = rag_pkg::ST_IDLE;
      end
      default: state_next = rag_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rag_pkg::ST_IDLE: begin
        if (accept) begin
          op <= rag_pkg::kind_t'(kind);
          an <= an_x;
          ad <= ad_x;
          bn <= bn_x;
          bd <= bd_x;
        end
      end
      rag_pkg::ST_MUL_N: pn <= RW'(prod);
      rag_pkg::ST_MUL_D: pd <= RW'(prod);
      rag_pkg::ST_MUL_X: px <= RW'(prod);
      rag_pkg::ST_COMB: begin
        n <= n_raw;
        d <= pd;
        g <= RW'(1);
        if (n_raw > pd) begin
          m <= n_raw;
          k <= pd;
        end else begin
          m <= pd;
          k <= n_raw;
        end
      end
      rag_pkg::ST_EUC_WAIT: begin
        if (div_done) begin
          if (rem == '0) begin
            g <= k;
          end else begin
            m <= k;
            k <= rem;
          end
        end
      end
      rag_pkg::ST_NUM_WAIT: begin
        if (div_done) n <= quo;
      end
      rag_pkg::ST_DEN_WAIT: begin
        if (div_done) d <= quo;
      end
      default: begin
      end
    endcase
  end

  assign res_num = rag_pkg::OUT_W'(n);
  assign res_den = rag_pkg::OUT_W'(d);

endmodule

FILE: rtl/core/rag_chk.sv
// port-level checker for the rational reduce block, with its bind
`timescale 1ns / 1ps
`include "rational_arith_gcd_reduce_macros.svh"
module rag_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [rag_pkg::OUT_W-1:0] res_num,
  input logic signed [rag_pkg::OUT_W-1:0] res_den
);

  // one item in flight: no intake while a result is shown
  `RAG_ASSERT(a_busy_when_out, out_valid |-> in_stall)
  // an accepted item closes the input side next cycle
  `RAG_ASSERT(a_accept_closes, (in_valid && !in_stall) |=> in_stall)
  // a held result keeps its value
  `RAG_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(res_num) && $stable(res_den)))
  // reset clears any pending result
  `RAG_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid)

endmodule

bind rational_arith_gcd_reduce rag_chk u_rag_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .res_num   (res_num),
  .res_den   (res_den)
);

FILE: test/rational_arith_gcd_reduce_checker.sv
// checker: watches both channels, predicts reduced fractions and compares
`timescale 1ns / 1ps
module rational_arith_gcd_reduce_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [1:0]                        kind,
  input  logic signed [rag_pkg::IN_W-1:0]   a_num,
  input  logic signed [rag_pkg::IN_W-1:0]   a_den,
  input  logic signed [rag_pkg::IN_W-1:0]   b_num,
  input  logic signed [rag_pkg::IN_W-1:0]   b_den,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [rag_pkg::OUT_W-1:0]  res_num,
  input  logic signed [rag_pkg::OUT_W-1:0]  res_den,
  output int                                fail_count,
  output int                                pending
);
  import rag_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] num;
    logic [OUT_W-1:0] den;
  } frac_t;

  frac_t expected_fracs[$];

  function automatic longint rem_trunc(longint x, longint y);
    if (y == -1) return 0;
    return x % y;
  endfunction

  function automatic longint div_trunc(longint x, longint y);
    if (y == -1) return -x;
    return x / y;
  endfunction

  function automatic longint euclid_divisor(longint n, longint d);
    longint m, k, r;
    if (n == 0 || d == 0) return 1;
    if (n > d) begin
      m = n;
      k = d;
    end else begin
      m = d;
      k = n;
    end
    r = rem_trunc(m, k);
    while (r != 0) begin
      m = k;
      k = r;
      r = rem_trunc(m, k);
    end
    return k;
  endfunction

  function automatic frac_t reduce_fraction(kind_t op, longint an, longint ad,
                                            longint bn, longint bd);
    longint n, d, g;
    frac_t f;
    case (op)
      KIND_ADD: begin
        n = an * bd + ad * bn;
        d = ad * bd;
      end
      KIND_SUB: begin
        n = an * bd - ad * bn;
        d = ad * bd;
      end
      KIND_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      default: begin
        n = an * bd;
        d = ad * bn;
      end
    endcase
    g = euclid_divisor(n, d);
    f.num = OUT_W'(div_trunc(n, g));
    f.den = OUT_W'(div_trunc(d, g));
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [OUT_W-1:0] got,
                                 logic [OUT_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    fail_count++;
  endtask

  assign pending = expected_fracs.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    frac_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_fracs.push_back(reduce_fraction(kind_t'(kind), longint'(a_num),
          longint'(a_den), longint'(b_num), longint'(b_den)));
      if (out_valid && !out_stall) begin
        if (expected_fracs.size() == 0) begin
          $display("unexpected result item %0d/%0d", res_num, res_den);
          fail_count++;
        end else begin
          want = expected_fracs.pop_front();
          if (res_num !== want.num) report_mismatch("res_num", res_num, want.num);
          if (res_den !== want.den) report_mismatch("res_den", res_den, want.den);
        end
      end
    end
  end
endmodule

FILE: test/tb_rational_arith_gcd_reduce.sv
// testbench top: stimulus, stalls, watchdog and verdict for the rational reduce block
`timescale 1ns / 1ps
module tb_rational_arith_gcd_reduce;
  import rag_pkg::*;

  localparam int N_RANDOM = 530;
  localparam int WATCHDOG = 20000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] kind;
  logic signed [IN_W-1:0] a_num, a_den, b_num, b_den;
  logic signed [OUT_W-1:0] res_num, res_den;
  int fail_count, pending, idle_cycles;
  bit stall_enable;

  rational_arith_gcd_reduce i_dut (.*);

  rational_arith_gcd_reduce_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  function automatic logic [IN_W-1:0] pick_operand();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return $urandom_range(1) ? 16'sh0001 : 16'shffff;
      4: return IN_W'($signed($urandom_range(0, 40)) - 20);
      default: return IN_W'($urandom);
    endcase
  endfunction

  // one item: hold valid until accepted
  task automatic send_item(kind_t op, logic [IN_W-1:0] an, logic [IN_W-1:0] ad,
                           logic [IN_W-1:0] bn, logic [IN_W-1:0] bd);
    in_valid <= 1'b1;
    kind <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver stall, with stall-free stretches
  always @(posedge clk) begin
    int p;
    p = $urandom_range(99);
    if (!stall_enable) out_stall <= 1'b0;
    else if (p < 8) out_stall <= 1'b1;
    else if (p < 45) out_stall <= out_stall;
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    kind_t op;
    in_valid = 0;
    out_stall = 0;
    kind = KIND_ADD;
    a_num = 0;
    a_den = 0;
    b_num = 0;
    b_den = 0;
    stall_enable = 0;
    idle_cycles = 0;
    rst = 1;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every kind, zero raw values, negative divisors
    send_item(KIND_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send_item(KIND_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
    send_item(KIND_MUL, 16'sd3, 16'sd4, 16'sd2, 16'sd9);
    send_item(KIND_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5);
    send_item(KIND_DIV, 16'sd0, 16'sd4, 16'sd7, 16'sd5);
    send_item(KIND_MUL, -16'sd6, 16'sd4, 16'sd2, -16'sd9);
    send_item(KIND_ADD, -16'sd1, 16'sd2, -16'sd1, 16'sd2);
    send_item(KIND_SUB, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(KIND_MUL, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_item(KIND_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(KIND_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_item(KIND_DIV, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_item(KIND_DIV, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
    send_item(KIND_MUL, 16'sd5, 16'sd0, 16'sd3, 16'sd7);
    send_item(KIND_SUB, 16'sd7, -16'sd3, 16'sd7, -16'sd3);
    send_item(KIND_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_item(KIND_DIV, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_item(KIND_MUL, 16'sd1, -16'sd1, -16'sd1, 16'sd1);
    send_item(KIND_SUB, 16'sd17, 16'sd4, -16'sd13, 16'sd6);

    // hold off until every expected result is back
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    stall_enable = 1;
    for (int i = 0; i < N_RANDOM; i++) begin
      op = kind_t'($urandom_range(3));
      send_item(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
      if (i > 100 && i < 200) stall_enable = 0;
      else stall_enable = 1;
      if (i % 3 != 0) pause(gap_len());
    end
    in_valid <= 1'b0;

    // let the checker record the last accepted item before polling
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rag_pkg.sv
rtl/core/rag_div.sv
rtl/core/rational_arith_gcd_reduce.sv
rtl/core/rag_chk.sv
test/rational_arith_gcd_reduce_checker.sv
test/tb_rational_arith_gcd_reduce.sv
